>>> hdl/dre_pkg.sv
// Shared types and constants for the DNS reply answer extractor.
// No dependencies; every other file in hdl/ except dre_if.sv imports this package.
package dre_pkg;

	// Defaults for the top-level parameters
	localparam int PAYLOAD_BYTES_DEF = 512;
	localparam int MAX_RDATA_DEF     = 1023;

	// Datagram layout
	localparam int HDR_LEN    = 12;
	localparam int RR_LEN     = 10;
	localparam int LABEL_MAX  = 63;
	localparam int Q_DEPTH    = 4;

	// Configuration register indexes
	localparam logic [1:0] REG_QUERY_ID    = 2'd0;
	localparam logic [1:0] REG_QUERY_TYPE  = 2'd1;
	localparam logic [1:0] REG_QUERY_CLASS = 2'd2;

	// Status codes of the final word
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RCODE     = 3'd1;
	localparam logic [2:0] ST_NO_ANSWER = 3'd2;
	localparam logic [2:0] ST_ID_MISM   = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;

	// Result word kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [15:0] query_id;
		logic [15:0] query_type;
		logic [15:0] query_class;
	} cfg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rdata_byte;
		logic [2:0] status;
		logic [3:0] rcode;
		logic [9:0] rdata_length;
		logic       last;
	} result_t;

	// Words one input byte may produce: an rdata word, then a status word
	typedef struct packed {
		logic    dat_vld;
		result_t dat_item;
		logic    sts_vld;
		result_t sts_item;
	} push_t;

endpackage

>>> hdl/dre_if.sv
// Valid/ready channel interfaces for the DNS reply answer extractor.
// Input channel carries datagram bytes, output channel carries result words.
interface dre_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dre_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] rdata_byte;
	logic [2:0] status;
	logic [3:0] rcode;
	logic [9:0] rdata_length;
	logic       last;

	modport source (output valid, output kind, output rdata_byte, output status,
		output rcode, output rdata_length, output last, input ready);
	modport sink (input valid, input kind, input rdata_byte, input status,
		input rcode, input rdata_length, input last, output ready);
endinterface

>>> hdl/dre_parser.sv
// Byte-serial parser: header checks, question skip, answer walk, rdata stream.
// Depends on dre_pkg; produces up to two result words per accepted byte.
module dre_parser
	import dre_pkg::*;
#(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	parameter int MAX_RDATA     = MAX_RDATA_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  cfg_t       cfg,
	output push_t      push
);

	localparam int POS_W  = $clog2(HDR_LEN + PAYLOAD_BYTES + 1);
	localparam int SKIP_W = $clog2(PAYLOAD_BYTES + 65536 + 1);
	localparam int RDL_W  = $clog2(MAX_RDATA + 1);

	typedef enum logic [2:0] {
		PH_HEADER, PH_QSKIP, PH_ANAME, PH_RRHDR, PH_RDATA, PH_MATCHED, PH_FAIL
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [15:0]         id_q, id_d;
	logic [7:0]          f1_q, f1_d;
	logic [7:0]          f2_q, f2_d;
	logic [15:0]         ancount_q, ancount_d;
	logic [15:0]         qleft_q, qleft_d;
	logic [15:0]         aseen_q, aseen_d;
	logic [SKIP_W-1:0]   skip_q, skip_d;
	logic [15:0]         rtype_q, rtype_d;
	logic [15:0]         rclass_q, rclass_d;
	logic [15:0]         rdlen_q, rdlen_d;
	logic [RDL_W-1:0]    rleft_q, rleft_d;
	logic [2:0]          oflag_q, oflag_d;

	logic [SKIP_W-1:0]   idx;
	logic [SKIP_W-1:0]   diff;
	logic [3:0]          off;
	logic [15:0]         rl;
	logic                emit_dat;
	logic [2:0]          st;
	logic [3:0]          rc;
	logic [9:0]          len;

	assign idx  = SKIP_W'(pos_q) - SKIP_W'(HDR_LEN);
	assign diff = idx - skip_q;
	assign off  = diff[3:0];
	assign rl   = {rdlen_q[7:0], data_byte};

	// Next parse state for the byte on the input
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		id_d      = id_q;
		f1_d      = f1_q;
		f2_d      = f2_q;
		ancount_d = ancount_q;
		qleft_d   = qleft_q;
		aseen_d   = aseen_q;
		skip_d    = skip_q;
		rtype_d   = rtype_q;
		rclass_d  = rclass_q;
		rdlen_d   = rdlen_q;
		rleft_d   = rleft_q;
		oflag_d   = oflag_q;
		emit_dat  = 1'b0;

		if (pos_q < POS_W'(HDR_LEN + PAYLOAD_BYTES)) begin
			pos_d = pos_q + POS_W'(1);
			if (pos_q < POS_W'(HDR_LEN)) begin
				// Collect header fields by byte offset
				case (pos_q[3:0])
					4'd0: id_d[15:8] = data_byte;
					4'd1: id_d[7:0] = data_byte;
					4'd2: f1_d = data_byte;
					4'd3: f2_d = data_byte;
					4'd4, 4'd5: qleft_d = {qleft_q[7:0], data_byte};
					4'd6, 4'd7: ancount_d = {ancount_q[7:0], data_byte};
					default: ;
				endcase
				// Judge the header on its last byte
				if (pos_q == POS_W'(HDR_LEN - 1)) begin
					if (id_q != cfg.query_id) begin
						phase_d = PH_FAIL;
						oflag_d = ST_ID_MISM;
					end else if (!f1_q[7] || f1_q[6:3] != 4'd0) begin
						phase_d = PH_FAIL;
						oflag_d = ST_MALFORMED;
					end else if (f2_q[3:0] != 4'd0) begin
						phase_d = PH_FAIL;
						oflag_d = ST_RCODE;
					end else if (ancount_q == 16'd0) begin
						phase_d = PH_FAIL;
						oflag_d = ST_NO_ANSWER;
					end else begin
						phase_d = (qleft_q != 16'd0) ? PH_QSKIP : PH_ANAME;
					end
				end
			end else if (idx >= skip_q) begin
				case (phase_q)
					// Skip question names, then the fixed type and class
					PH_QSKIP: begin
						if (data_byte > 8'(LABEL_MAX)) begin
							skip_d  = idx + SKIP_W'(6);
							qleft_d = qleft_q - 16'd1;
						end else if (data_byte == 8'd0) begin
							skip_d  = idx + SKIP_W'(5);
							qleft_d = qleft_q - 16'd1;
						end else begin
							skip_d = idx + SKIP_W'(data_byte) + SKIP_W'(1);
						end
						if (qleft_d == 16'd0) begin
							phase_d = PH_ANAME;
						end
					end
					// Skip the owner name of an answer record
					PH_ANAME: begin
						if (data_byte > 8'(LABEL_MAX)) begin
							skip_d  = idx + SKIP_W'(2);
							phase_d = PH_RRHDR;
						end else if (data_byte == 8'd0) begin
							skip_d  = idx + SKIP_W'(1);
							phase_d = PH_RRHDR;
						end else begin
							skip_d = idx + SKIP_W'(data_byte) + SKIP_W'(1);
						end
					end
					// Collect type, class and rdlength, then decide on the record
					PH_RRHDR: begin
						case (off)
							4'd0: rtype_d[15:8] = data_byte;
							4'd1: rtype_d[7:0] = data_byte;
							4'd2: rclass_d[15:8] = data_byte;
							4'd3: rclass_d[7:0] = data_byte;
							4'd8, 4'd9: rdlen_d = rl;
							default: ;
						endcase
						if (off == 4'(RR_LEN - 1)) begin
							skip_d = idx + SKIP_W'(1);
							if (rtype_q != cfg.query_type || rclass_q != cfg.query_class) begin
								aseen_d = aseen_q + 16'd1;
								skip_d  = idx + SKIP_W'(1) + SKIP_W'(rl);
								if (({1'b0, aseen_q} + 17'd1) >= {1'b0, ancount_q}) begin
									phase_d = PH_FAIL;
									oflag_d = ST_MALFORMED;
								end else begin
									phase_d = PH_ANAME;
								end
							end else if (rl > 16'(MAX_RDATA)) begin
								phase_d = PH_FAIL;
								oflag_d = ST_MALFORMED;
							end else begin
								rleft_d = rl[RDL_W-1:0];
								phase_d = (rl != 16'd0) ? PH_RDATA : PH_MATCHED;
							end
						end
					end
					// Stream the matched record's data
					PH_RDATA: begin
						rleft_d  = rleft_q - RDL_W'(1);
						emit_dat = 1'b1;
						if (rleft_q == RDL_W'(1)) begin
							phase_d = PH_MATCHED;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Final status from the state after this byte
	always_comb begin
		st  = ST_MALFORMED;
		rc  = 4'd0;
		len = 10'd0;
		if (pos_d < POS_W'(HDR_LEN)) begin
			st = ST_MALFORMED;
		end else if (phase_d == PH_FAIL) begin
			st = oflag_d;
			if (oflag_d == ST_RCODE) begin
				rc = f2_d[3:0];
			end
		end else if (phase_d == PH_MATCHED) begin
			st  = ST_OK;
			len = rdlen_d[9:0];
		end
	end

	// Words handed to the output queue
	always_comb begin
		push.dat_vld               = step && emit_dat;
		push.dat_item.kind         = KIND_DATA;
		push.dat_item.rdata_byte   = data_byte;
		push.dat_item.status       = ST_OK;
		push.dat_item.rcode        = 4'd0;
		push.dat_item.rdata_length = 10'd0;
		push.dat_item.last         = 1'b0;
		push.sts_vld               = step && last_byte;
		push.sts_item.kind         = KIND_STATUS;
		push.sts_item.rdata_byte   = 8'd0;
		push.sts_item.status       = st;
		push.sts_item.rcode        = rc;
		push.sts_item.rdata_length = len;
		push.sts_item.last         = 1'b1;
	end

	// Hold parse state; advance on each accepted byte, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			id_q      <= '0;
			f1_q      <= '0;
			f2_q      <= '0;
			ancount_q <= '0;
			qleft_q   <= '0;
			aseen_q   <= '0;
			skip_q    <= '0;
			rtype_q   <= '0;
			rclass_q  <= '0;
			rdlen_q   <= '0;
			rleft_q   <= '0;
			oflag_q   <= '0;
		end else if (step) begin
			if (last_byte) begin
				phase_q   <= PH_HEADER;
				pos_q     <= '0;
				id_q      <= '0;
				f1_q      <= '0;
				f2_q      <= '0;
				ancount_q <= '0;
				qleft_q   <= '0;
				aseen_q   <= '0;
				skip_q    <= '0;
				rtype_q   <= '0;
				rclass_q  <= '0;
				rdlen_q   <= '0;
				rleft_q   <= '0;
				oflag_q   <= '0;
			end else begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				id_q      <= id_d;
				f1_q      <= f1_d;
				f2_q      <= f2_d;
				ancount_q <= ancount_d;
				qleft_q   <= qleft_d;
				aseen_q   <= aseen_d;
				skip_q    <= skip_d;
				rtype_q   <= rtype_d;
				rclass_q  <= rclass_d;
				rdlen_q   <= rdlen_d;
				rleft_q   <= rleft_d;
				oflag_q   <= oflag_d;
			end
		end
	end

endmodule

>>> hdl/dre_out_queue.sv
// Small result queue: takes up to two words per cycle, releases one per cycle.
// Depends on dre_pkg for the word and push types.
module dre_out_queue
	import dre_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output logic    room,
	output logic    head_vld,
	output result_t head
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	result_t          mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       n_push;
	logic [PTR_W-1:0] sts_ptr;

	assign n_push   = {1'b0, push.dat_vld} + {1'b0, push.sts_vld};
	assign sts_ptr  = wp_q + PTR_W'(push.dat_vld);
	assign room     = cnt_q <= CNT_W'(Q_DEPTH - 2);
	assign head_vld = cnt_q != '0;
	assign head     = mem_q[rp_q];

	// Store words: data word first, status word behind it
	always_ff @(posedge clk) begin
		if (push.dat_vld) begin
			mem_q[wp_q] <= push.dat_item;
		end
		if (push.sts_vld) begin
			mem_q[sts_ptr] <= push.sts_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(n_push);
			rp_q  <= rp_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

>>> hdl/dns_response_answer_extractor.sv
// DNS reply answer extractor, top level. Depends on dre_pkg, dre_if, dre_parser, dre_out_queue.
// Throughput: one datagram byte per cycle while ready is high; the byte that carries last can make two words,
// so ready is low whenever the four-word output queue holds more than two words.
// Output: a result word is valid on the output in the cycle after its byte is accepted when
// the queue ahead of it is empty; words already queued and dout stalls delay it further.
// Reset: arst_n clears the parse state and the queue, sets query_id 0, type 1, class 1.
module dns_response_answer_extractor
	import dre_pkg::*;
#(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	parameter int MAX_RDATA     = MAX_RDATA_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dre_in_if.sink      din,
	dre_out_if.source   dout,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t    cfg_q;
	push_t   push;
	logic    step;
	logic    room;
	logic    head_vld;
	result_t head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.query_id    <= 16'd0;
			cfg_q.query_type  <= 16'd1;
			cfg_q.query_class <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUERY_ID:    cfg_q.query_id <= cfg_data;
				REG_QUERY_TYPE:  cfg_q.query_type <= cfg_data;
				REG_QUERY_CLASS: cfg_q.query_class <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept a byte whenever the queue can take two more words
	assign din.ready = room;
	assign step      = din.valid && room;

	dre_parser #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.MAX_RDATA     (MAX_RDATA)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (din.data_byte),
		.last_byte (din.last_byte),
		.cfg       (cfg_q),
		.push      (push)
	);

	dre_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (head_vld && dout.ready),
		.room     (room),
		.head_vld (head_vld),
		.head     (head)
	);

	// Drive the output channel from the queue head
	assign dout.valid        = head_vld;
	assign dout.kind         = head.kind;
	assign dout.rdata_byte   = head.rdata_byte;
	assign dout.status       = head.status;
	assign dout.rcode        = head.rcode;
	assign dout.rdata_length = head.rdata_length;
	assign dout.last         = head.last;

endmodule

>>> verif/dre_answer_checker.sv
`timescale 1ns / 100ps
// Result checker for the DNS reply answer extractor: predicts every result word
// from the accepted datagram bytes and register writes, then compares. Needs dre_pkg, dre_if.
module dre_answer_checker
	import dre_pkg::*;
#(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	parameter int MAX_RDATA     = MAX_RDATA_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dre_in_if           din,
	dre_out_if          dout,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef enum logic [3:0] {
		S_HDR_BYTES, S_QUESTION, S_ANS_NAME, S_REC_HDR, S_RDATA, S_MATCHED, S_FAILED
	} parse_phase_t;

	// Configuration copy
	logic [15:0] cfg_id, cfg_type, cfg_class;

	// Parse state of the datagram in flight
	logic [9:0]   byte_count;
	parse_phase_t phase;
	logic [47:0]  hdr_reg;   // id, flags1, flags2, answer count
	logic [15:0]  qd_left;
	logic [15:0]  an_walked;
	logic [16:0]  next_idx;  // payload index of the next byte that decides anything
	logic [47:0]  rec_reg;   // type, class, rdlength
	logic [15:0]  rd_left;
	logic [3:0]   fail_code;

	result_t expected_words[$];
	int      errs = 0;

	assign fail_count = errs;

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
		errs++;
	endtask

	task automatic restart_parse();
		byte_count = '0;
		phase      = S_HDR_BYTES;
		hdr_reg    = '0;
		qd_left    = '0;
		an_walked  = '0;
		next_idx   = '0;
		rec_reg    = '0;
		rd_left    = '0;
		fail_code  = '0;
	endtask

	// Advance the parse by one datagram byte; queue the words it causes
	task automatic parse_byte(input logic [7:0] b, input logic lb);
		int          pos;
		int          off;
		logic [16:0] idx;
		result_t     w;
		pos = int'(byte_count);
		if (pos < HDR_LEN + PAYLOAD_BYTES) begin
			if (pos < HDR_LEN) begin
				// collect the header fields
				if (pos < 4)
					hdr_reg[8 * (5 - pos) +: 8] = hdr_reg[8 * (5 - pos) +: 8] | b;
				else if (pos < 6)
					qd_left = {qd_left[7:0], b};
				else if (pos < 8)
					hdr_reg[15:0] = {hdr_reg[7:0], b};
				// judge the header on its final byte
				if (pos == HDR_LEN - 1) begin
					if (hdr_reg[47:32] != cfg_id) begin
						phase = S_FAILED;
						fail_code = {1'b0, ST_ID_MISM};
					end else if (!hdr_reg[31] || hdr_reg[30:27] != 4'h0) begin
						phase = S_FAILED;
						fail_code = {1'b0, ST_MALFORMED};
					end else if (hdr_reg[19:16] != 4'h0) begin
						phase = S_FAILED;
						fail_code = {1'b0, ST_RCODE};
					end else if (hdr_reg[15:0] == 16'h0) begin
						phase = S_FAILED;
						fail_code = {1'b0, ST_NO_ANSWER};
					end else begin
						phase = (qd_left != 16'h0) ? S_QUESTION : S_ANS_NAME;
					end
				end
			end else begin
				idx = 17'(pos - HDR_LEN);
				if (phase != S_FAILED && phase != S_MATCHED && idx >= next_idx) begin
					case (phase)
						S_QUESTION: begin
							// pointer or root ends the name, then type and class follow
							if (b > LABEL_MAX) begin
								next_idx = idx + 17'd6;
								qd_left = qd_left - 16'd1;
							end else if (b == 8'h00) begin
								next_idx = idx + 17'd5;
								qd_left = qd_left - 16'd1;
							end else begin
								next_idx = idx + 17'(b) + 17'd1;
							end
							if (qd_left == 16'h0)
								phase = S_ANS_NAME;
						end
						S_ANS_NAME: begin
							if (b > LABEL_MAX) begin
								next_idx = idx + 17'd2;
								phase = S_REC_HDR;
							end else if (b == 8'h00) begin
								next_idx = idx + 17'd1;
								phase = S_REC_HDR;
							end else begin
								next_idx = idx + 17'(b) + 17'd1;
							end
						end
						S_REC_HDR: begin
							off = int'(idx - next_idx);
							if (off < 4)
								rec_reg[8 * (5 - off) +: 8] = b;
							else if (off >= 8)
								rec_reg[15:0] = {rec_reg[7:0], b};
							if (off == RR_LEN - 1) begin
								next_idx = idx + 17'd1;
								if (rec_reg[47:32] != cfg_type || rec_reg[31:16] != cfg_class) begin
									// skip this record's data and walk on
									an_walked = an_walked + 16'd1;
									next_idx = next_idx + 17'(rec_reg[15:0]);
									if (an_walked >= hdr_reg[15:0]) begin
										phase = S_FAILED;
										fail_code = {1'b0, ST_MALFORMED};
									end else begin
										phase = S_ANS_NAME;
									end
								end else if (int'(rec_reg[15:0]) > MAX_RDATA) begin
									phase = S_FAILED;
									fail_code = {1'b0, ST_MALFORMED};
								end else begin
									rd_left = rec_reg[15:0];
									phase = (rd_left != 16'h0) ? S_RDATA : S_MATCHED;
								end
							end
						end
						S_RDATA: begin
							rd_left = rd_left - 16'd1;
							if (rd_left == 16'h0)
								phase = S_MATCHED;
							w = '0;
							w.kind = KIND_DATA;
							w.rdata_byte = b;
							expected_words.push_back(w);
						end
						default: ;
					endcase
				end
			end
			byte_count = byte_count + 10'd1;
		end

		// close the datagram with its status word
		if (lb) begin
			w = '0;
			w.kind = KIND_STATUS;
			w.last = 1'b1;
			if (int'(byte_count) < HDR_LEN) begin
				w.status = ST_MALFORMED;
			end else if (phase == S_FAILED) begin
				w.status = fail_code[2:0];
				if (w.status == ST_RCODE)
					w.rcode = hdr_reg[19:16];
			end else if (phase == S_MATCHED) begin
				w.status = ST_OK;
				w.rdata_length = rec_reg[9:0];
			end else begin
				w.status = ST_MALFORMED;
			end
			expected_words.push_back(w);
			restart_parse();
		end
	endtask

	// Track writes and bytes, compare each delivered word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg_id    <= 16'h0000;
			cfg_type  <= 16'h0001;
			cfg_class <= 16'h0001;
			restart_parse();
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_QUERY_ID:    cfg_id    <= cfg_data;
					REG_QUERY_TYPE:  cfg_type  <= cfg_data;
					REG_QUERY_CLASS: cfg_class <= cfg_data;
					default: ;
				endcase
			end
			if (din.valid && din.ready)
				parse_byte(din.data_byte, din.last_byte);
			if (dout.valid && dout.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("word with nothing expected", dout.kind, 0);
				end else begin
					want = expected_words.pop_front();
					if (dout.kind !== want.kind)
						report_mismatch("kind", dout.kind, want.kind);
					if (dout.rdata_byte !== want.rdata_byte)
						report_mismatch("rdata_byte", dout.rdata_byte, want.rdata_byte);
					if (dout.status !== want.status)
						report_mismatch("status", dout.status, want.status);
					if (dout.rcode !== want.rcode)
						report_mismatch("rcode", dout.rcode, want.rcode);
					if (dout.rdata_length !== want.rdata_length)
						report_mismatch("rdata_length", dout.rdata_length, want.rdata_length);
					if (dout.last !== want.last)
						report_mismatch("last", dout.last, want.last);
				end
			end
		end
		// words still owed by the block
		pending = expected_words.size();
	end

endmodule

>>> verif/dns_response_answer_extractor_tb.sv
`timescale 1ns / 100ps
// Testbench top for the DNS reply answer extractor: clock, reset, datagram stimulus,
// register phases, output stalls and the verdict. Needs dre_pkg, dre_if, dre_answer_checker and the top level.
module dns_response_answer_extractor_tb;
	import dre_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_BYTES = 200;
	localparam int PHASES      = 6;

	typedef enum int {
		F_NONE, F_ID, F_QR, F_OPCODE, F_RCODE, F_NO_AN, F_AN_COUNT, F_QD_COUNT
	} fault_t;

	typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	bit          hold_req = 1'b0;

	// Stimulus state
	logic [7:0]  frame[$];
	logic [15:0] cur_id = 16'h0000;
	logic [15:0] cur_type = 16'h0001;
	logic [15:0] cur_class = 16'h0001;
	int          burst_left = 0;
	int          sent = 0;

	dre_in_if  in_ch ();
	dre_out_if out_ch ();

	dns_response_answer_extractor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (in_ch),
		.dout      (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dre_answer_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (in_ch),
		.dout       (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL dns_response_answer_extractor");
			$finish;
		end
	end

	// Receiver: change stall mode now and then; hold off entirely on request
	initial begin
		rx_mode_t mode;
		int       span;
		int       i;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(32, 400);
			for (i = 0; i < span && !hold_req; i++) begin
				@(posedge clk);
				case (mode)
					RX_OPEN:   out_ch.ready <= 1'b1;
					RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
					default:   out_ch.ready <= ($urandom_range(0, 9) == 0);
				endcase
			end
			if (hold_req) begin
				@(posedge clk);
				out_ch.ready <= 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// Offer one byte, in bursts with random gaps, and wait for its acceptance
	task automatic send_byte(input logic [7:0] b, input logic lb);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= lb;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
		sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == frame.size() - 1);
	endtask

	// Drop valid and wait until every predicted word has been delivered
	task automatic settle();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	task automatic put16(input logic [15:0] v);
		frame.push_back(v[15:8]);
		frame.push_back(v[7:0]);
	endtask

	// Name: up to two labels, then a root byte or a two-byte pointer
	task automatic put_name();
		int labels;
		int len;
		int i;
		int j;
		labels = $urandom_range(0, 2);
		for (i = 0; i < labels; i++) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, LABEL_MAX) : $urandom_range(1, 6);
			frame.push_back(8'(len));
			for (j = 0; j < len; j++)
				frame.push_back(8'($urandom));
		end
		if ($urandom_range(0, 1) == 1) begin
			frame.push_back(8'($urandom_range(LABEL_MAX + 1, 255)));
			frame.push_back(8'($urandom));
		end else begin
			frame.push_back(8'h00);
		end
	endtask

	// Build a reply for the current query, mostly well formed, sometimes damaged;
	// long_tail pads a matched reply far past the payload capacity
	task automatic build_reply(input bit long_tail);
		fault_t      fault;
		int          qd;
		int          nrec;
		int          hit;
		int          n;
		int          i;
		int          j;
		logic [15:0] id, qdcount, ancount, ty, cl, rl;
		logic [7:0]  f1, f2;
		frame.delete();
		id = cur_id;
		f1 = 8'h80 | 8'($urandom_range(0, 7));
		f2 = {4'($urandom), 4'h0};
		qd = $urandom_range(0, 2);
		nrec = $urandom_range(1, 3);
		qdcount = 16'(qd);
		ancount = 16'(nrec);
		fault = F_NONE;
		if (!long_tail && $urandom_range(0, 3) == 0)
			fault = fault_t'($urandom_range(1, 7));
		case (fault)
			F_ID:       id = id ^ 16'($urandom_range(1, 65535));
			F_QR:       f1[7] = 1'b0;
			F_OPCODE:   f1[6:3] = 4'($urandom_range(1, 15));
			F_RCODE:    f2[3:0] = 4'($urandom_range(1, 15));
			F_NO_AN:    ancount = 16'h0000;
			F_AN_COUNT: ancount = 16'($urandom);
			F_QD_COUNT: qdcount = 16'($urandom);
			default: ;
		endcase
		// hit == nrec means no record carries the query type and class
		hit = long_tail ? 0 : $urandom_range(0, nrec);

		put16(id);
		frame.push_back(f1);
		frame.push_back(f2);
		put16(qdcount);
		put16(ancount);
		put16(16'($urandom));
		put16(16'($urandom));
		for (i = 0; i < qd; i++) begin
			put_name();
			put16(16'($urandom));
			put16(16'($urandom));
		end
		for (i = 0; i < nrec; i++) begin
			put_name();
			if (i == hit) begin
				ty = cur_type;
				cl = cur_class;
				n = $urandom_range(0, 15);
				if (long_tail)
					rl = 16'($urandom_range(4, 12));
				else if (n == 0)
					rl = 16'(MAX_RDATA_DEF + $urandom_range(0, 1));
				else if (n == 1)
					rl = 16'($urandom_range(MAX_RDATA_DEF + 1, 65535));
				else if (n == 2)
					rl = 16'($urandom_range(13, 60));
				else
					rl = 16'($urandom_range(0, 12));
			end else begin
				// differ in type, in class, or in both
				ty = 16'($urandom);
				cl = 16'($urandom);
				n = $urandom_range(0, 2);
				if (n == 1)
					ty = cur_type;
				else if (n == 2)
					cl = cur_class;
				if (ty == cur_type && cl == cur_class)
					cl = ~cl;
				rl = 16'($urandom_range(0, 8));
			end
			put16(ty);
			put16(cl);
			put16(16'($urandom));
			put16(16'($urandom));
			put16(rl);
			// huge lengths are cut short: the datagram ends before the data does
			n = (rl > 16'd64) ? $urandom_range(0, 8) : int'(rl);
			for (j = 0; j < n; j++)
				frame.push_back(8'($urandom));
		end
		n = long_tail ? 540 : $urandom_range(0, 3);
		for (j = 0; j < n; j++)
			frame.push_back(8'($urandom));
		// truncate now and then, down to a partial header
		if (!long_tail && $urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, frame.size());
			while (frame.size() > n)
				void'(frame.pop_back());
		end
	endtask

	// Stimulus and verdict
	initial begin
		int ph;
		int budget;
		int i;
		int n;
		bit long_done;
		in_ch.valid     <= 1'b0;
		in_ch.data_byte <= 8'h00;
		in_ch.last_byte <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_QUERY_ID;
		cfg_data        <= 16'h0000;
		long_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: one-byte datagrams at both byte extremes, then a minimal match
		frame = '{8'h00};
		send_frame();
		frame = '{8'hFF};
		send_frame();
		frame = '{8'h00, 8'h00, 8'h81, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF};
		send_frame();

		// Random: one register setting per phase, reset values first
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph != 0) begin
				if (ph == 1) begin
					cur_id = 16'h0000;
					cur_type = 16'h0000;
					cur_class = 16'h0000;
				end else if (ph == 2) begin
					cur_id = 16'hFFFF;
					cur_type = 16'hFFFF;
					cur_class = 16'hFFFF;
				end else begin
					cur_id = 16'($urandom);
					cur_type = ($urandom_range(0, 1) == 1) ? 16'h0001 : 16'($urandom);
					cur_class = ($urandom_range(0, 3) != 0) ? 16'h0001 : 16'($urandom);
				end
				cfg_write(REG_QUERY_ID, cur_id);
				cfg_write(REG_QUERY_TYPE, cur_type);
				cfg_write(REG_QUERY_CLASS, cur_class);
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			budget = sent + PHASE_BYTES;
			while (sent < budget) begin
				if (ph == 3 && !long_done) begin
					// stall the receiver while a long reply keeps coming
					hold_req = 1'b1;
					build_reply(1'b1);
					long_done = 1'b1;
				end else if ($urandom_range(0, 9) == 0) begin
					frame.delete();
					n = $urandom_range(1, 24);
					for (i = 0; i < n; i++)
						frame.push_back(8'($urandom));
				end else begin
					build_reply(1'b0);
				end
				send_frame();
				if ($urandom_range(0, 15) == 0)
					settle();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS dns_response_answer_extractor");
		else
			$display("FAIL dns_response_answer_extractor");
		$finish;
	end

endmodule
